FILE: src/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants of the record selection sorter.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int KEY_W       = 32;
  localparam int DEPT_W      = 2;
  localparam int TAG_W       = 16;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [DEPT_W-1:0]       dept;
    logic [TAG_W-1:0]        tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_FIRST,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;       // input transaction this cycle
    logic start;      // set closed, begin sort at position 0
    logic fetch;      // read entry at current position
    logic first;      // capture entry at current position
    logic scan;       // compare candidate, read next
    logic emit_done;  // output transaction, write back displaced record
  } ctrl_cmd_t;

  typedef struct packed {
    logic more_j;     // candidates remain to be read
    logic last_pos;   // current position is the final one
  } dp_status_t;

endpackage

FILE: src/rss_in_if.sv
// ----------------------------------------------------------------------------
// rss_in_if
// Record load channel: valid/ready with one record and a last flag.
// ----------------------------------------------------------------------------
interface rss_in_if;
  import rss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key;
  logic [DEPT_W-1:0]       dept;
  logic [TAG_W-1:0]        tag;
  logic                    load_last;

  modport source (output valid, key, dept, tag, load_last, input ready);
  modport sink   (input valid, key, dept, tag, load_last, output ready);
endinterface

FILE: src/rss_out_if.sv
// ----------------------------------------------------------------------------
// rss_out_if
// Sorted record channel: valid/ready with one record, last and overflow flags.
// ----------------------------------------------------------------------------
interface rss_out_if;
  import rss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] sorted_key;
  logic [DEPT_W-1:0]       sorted_dept;
  logic [TAG_W-1:0]        sorted_tag;
  logic                    out_last;
  logic                    overflowed;

  modport source (output valid, sorted_key, sorted_dept, sorted_tag, out_last, overflowed,
                  input ready);
  modport sink   (input valid, sorted_key, sorted_dept, sorted_tag, out_last, overflowed,
                  output ready);
endinterface

FILE: src/record_selection_sorter.sv
// ----------------------------------------------------------------------------
// record_selection_sorter
// Loads a set of records, sorts them by signed key with selection sort
// (ascending or descending) and streams them out in order.
//
//   channel   dir   handshake        payload
//   rec_i     in    valid/ready      key, dept, tag, load_last
//   rec_o     out   valid/ready      sorted_key, sorted_dept, sorted_tag,
//                                    out_last, overflowed
//   cfg       in    cfg_we_i         cfg_wdata_i (descending)
//
// Loading accepts one record transaction per cycle. After the last record the
// block sorts out of a single-read RAM: each output position takes a fetch
// of the entry at that position, a scan over the later entries and an emit,
// and loading resumes once the last position is emitted. The scan reads one
// entry a cycle.
// Reset clears counters and the sequencer; the record store needs no clear.
// Output stalls hold the emitted record; no loads are taken during the sort.
// ----------------------------------------------------------------------------
module record_selection_sorter (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  rss_in_if.sink    rec_i,
  rss_out_if.source rec_o
);
  import rss_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  rss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rec_i.valid),
    .in_last_i   (rec_i.load_last),
    .in_ready_o  (rec_i.ready),
    .out_valid_o (rec_o.valid),
    .out_ready_i (rec_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_key_i    (rec_i.key),
    .in_dept_i   (rec_i.dept),
    .in_tag_i    (rec_i.tag),
    .out_key_o   (rec_o.sorted_key),
    .out_dept_o  (rec_o.sorted_dept),
    .out_tag_o   (rec_o.sorted_tag),
    .out_last_o  (rec_o.out_last),
    .out_ovf_o   (rec_o.overflowed)
  );

endmodule

FILE: src/rss_ram.sv
// ----------------------------------------------------------------------------
// rss_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rss_ctrl.sv
// ----------------------------------------------------------------------------
// rss_ctrl
// Sequencer: load phase, then per position fetch, scan and emit.
// ----------------------------------------------------------------------------
module rss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rss_pkg::dp_status_t sts_i,
  output rss_pkg::ctrl_cmd_t  cmd_o
);
  import rss_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_last_i) state_d = ST_FETCH;
      end
      ST_FETCH: state_d = ST_FIRST;
      ST_FIRST, ST_SCAN: begin
        if (!sts_i.more_j) state_d = ST_EMIT;
        else               state_d = ST_SCAN;
      end
      ST_EMIT: begin
        if (out_ready_i) state_d = sts_i.last_pos ? ST_LOAD : ST_FETCH;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
        cmd_o.start = in_valid_i & in_last_i;
      end
      ST_FETCH: cmd_o.fetch = 1'b1;
      ST_FIRST: cmd_o.first = 1'b1;
      ST_SCAN:  cmd_o.scan  = 1'b1;
      ST_EMIT: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_done = out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

FILE: src/rss_dp.sv
// ----------------------------------------------------------------------------
// rss_dp
// Record store, counters, running extreme and swap write-back.
// ----------------------------------------------------------------------------
module rss_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rss_pkg::ctrl_cmd_t                cmd_i,
  output rss_pkg::dp_status_t               sts_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic signed [rss_pkg::KEY_W-1:0]  in_key_i,
  input  logic [rss_pkg::DEPT_W-1:0]        in_dept_i,
  input  logic [rss_pkg::TAG_W-1:0]         in_tag_i,
  output logic signed [rss_pkg::KEY_W-1:0]  out_key_o,
  output logic [rss_pkg::DEPT_W-1:0]        out_dept_o,
  output logic [rss_pkg::TAG_W-1:0]         out_tag_o,
  output logic                              out_last_o,
  output logic                              out_ovf_o
);
  import rss_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             desc_q;
  logic [IDX_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] pick_q, pick_d;
  rec_t             best_q, best_d;
  rec_t             reci_q;

  logic             room;
  logic             better;
  logic             we;
  logic [IDX_W-1:0] waddr;
  rec_t             wdata;
  rec_t             in_rec;
  logic             re;
  logic [IDX_W-1:0] raddr;
  rec_t             rdata;

  assign room          = count_q < CNT_W'(MAX_RECORDS);
  assign sts_o.more_j  = j_q < count_q;
  assign sts_o.last_pos = {1'b0, i_q} == CNT_W'(count_q - CNT_W'(1));

  assign in_rec = '{key: in_key_i, dept: in_dept_i, tag: in_tag_i};

  assign we    = (cmd_i.load & room) | cmd_i.emit_done;
  assign waddr = cmd_i.emit_done ? pick_q : count_q[IDX_W-1:0];
  assign wdata = cmd_i.emit_done ? reci_q : in_rec;
  assign re    = cmd_i.fetch | ((cmd_i.first | cmd_i.scan) & sts_o.more_j);
  assign raddr = cmd_i.fetch ? i_q : j_q[IDX_W-1:0];

  rss_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign better = desc_q ? (best_q.key < rdata.key) : (rdata.key < best_q.key);

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    i_d     = i_q;
    j_d     = j_q;
    pick_d  = pick_q;
    best_d  = best_q;
    if (cmd_i.load) begin
      if (room) count_d = CNT_W'(count_q + CNT_W'(1));
      else      ovf_d   = 1'b1;
    end
    if (cmd_i.start) i_d = '0;
    if (cmd_i.fetch) j_d = CNT_W'({1'b0, i_q} + CNT_W'(1));
    if ((cmd_i.first | cmd_i.scan) && sts_o.more_j) j_d = CNT_W'(j_q + CNT_W'(1));
    if (cmd_i.first) begin
      best_d = rdata;
      pick_d = i_q;
    end
    if (cmd_i.scan && better) begin
      best_d = rdata;
      pick_d = IDX_W'(j_q - CNT_W'(1));
    end
    if (cmd_i.emit_done) begin
      i_d = IDX_W'(i_q + IDX_W'(1));
      if (sts_o.last_pos) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      desc_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      pick_q  <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      pick_q  <= pick_d;
      if (cfg_we_i) desc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    if (cmd_i.first) reci_q <= rdata;
  end

  assign out_key_o  = best_q.key;
  assign out_dept_o = best_q.dept;
  assign out_tag_o  = best_q.tag;
  assign out_last_o = sts_o.last_pos;
  assign out_ovf_o  = ovf_q;

endmodule
